// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// ===== rtl/swa_pkg.sv =====
// Shared constants and types of the sliding window average.
package swa_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 64;
  localparam int unsigned SAMPLE_BITS_DEF  = 16;

  // Width of the window length register and of the fill count.
  localparam int unsigned LEN_BITS = 7;
  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_NEG,
    ST_DONE
  } swa_state_e;

endpackage

// ===== rtl/swa_if.sv =====
// Valid/ready channel interfaces for samples in and averages out.
interface swa_in_if #(
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swa_out_if #(
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean_value;
  logic                          window_full;

  modport source (output valid, output mean_value, output window_full, input ready);
  modport sink   (input valid, input mean_value, input window_full, output ready);
endinterface

// ===== rtl/sliding_window_average.sv =====
// Moving average over a ring of samples, bit-serial sum update and division.
// Each sample runs through the serial sum, division and negate states before its result
//   is loaded out (SUM_BITS = SAMPLE_BITS + clog2(min(WINDOW_DEPTH, 127))).
// Input is taken only when idle, after the bit-serial adder and restoring divider finish.
// The next sample is taken while a finished result still waits in the output register.
// Reset: async active low; length 16, sum, fill count and write slot zero; ring undefined.
`include "assert_macros.svh"

module sliding_window_average #(
  parameter int unsigned WINDOW_DEPTH = swa_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS  = swa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swa_pkg::LEN_BITS-1:0]  cfg_data_i,
  swa_in_if.sink                        smp_i,
  swa_out_if.source                     avg_o
);
  import swa_pkg::*;

  localparam int unsigned MAX_REG   = (1 << LEN_BITS) - 1;
  localparam int unsigned MAX_LEN   = (WINDOW_DEPTH < MAX_REG) ? WINDOW_DEPTH : MAX_REG;
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + $clog2(MAX_LEN);
  localparam int unsigned SLOT_BITS = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW        = ((LEN_BITS > SLOT_BITS) ? LEN_BITS : SLOT_BITS) + 2;
  localparam int unsigned CNT_BITS  = $clog2(SUM_BITS);

  swa_state_e state_q, state_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic [LEN_BITS-1:0]    wl_q, fill_q, div_q, len, fill_inc, rem_q;
  logic [SLOT_BITS-1:0]   slot_q, cur_slot, next_slot;
  logic [CW-1:0]          wl_w, len_w, slot_w, cur_w, slot_nx;
  logic [SUM_BITS-1:0]    sum_q, neg_q, dvd_q;
  logic [SAMPLE_BITS-1:0] smp_q, old_q, res_q, mean_q;
  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
  logic                   c1_q, c2_q, seen_q, sign_q, sub_q, full_q, full_out_q, out_valid_q;
  logic                   accept, filling, load_out, in_ready, sum_last, div_last, neg_last;
  logic                   bit_a, bit_b, bit_o, t1, c1_n, sbit, c2_n, nbit, qb, rbit;
  logic [LEN_BITS:0]      trial, trial_sub;
  logic                   ge;

  // Effective window length: zero reads as one, saturate to the ring depth.
  always_comb begin
    wl_w = CW'(wl_q);
    if (wl_q == '0) begin
      len_w = CW'(1);
    end else if (wl_w > CW'(WINDOW_DEPTH)) begin
      len_w = CW'(WINDOW_DEPTH);
    end else begin
      len_w = wl_w;
    end
  end

  assign len       = len_w[LEN_BITS-1:0];
  assign slot_w    = CW'(slot_q);
  assign cur_w     = (slot_w >= len_w) ? '0 : slot_w;
  assign cur_slot  = cur_w[SLOT_BITS-1:0];
  assign slot_nx   = cur_w + CW'(1);
  assign next_slot = (slot_nx >= len_w) ? '0 : slot_nx[SLOT_BITS-1:0];
  assign filling   = (fill_q < len);
  assign fill_inc  = fill_q + LEN_BITS'(1);
  assign accept    = smp_i.valid && in_ready;

  assign sum_last = (cnt_q == CNT_BITS'(SUM_BITS - 1));
  assign div_last = sum_last;
  assign neg_last = (cnt_q == CNT_BITS'(SAMPLE_BITS - 1));

  // Serial sum: sum + new + (~old + 1 when the oldest sample leaves), LSB first.
  assign bit_a = sum_q[0];
  assign bit_b = smp_q[0];
  assign bit_o = sub_q & ~old_q[0];
  assign t1    = bit_a ^ bit_b ^ c1_q;
  assign c1_n  = (bit_a & bit_b) | (bit_a & c1_q) | (bit_b & c1_q);
  assign sbit  = t1 ^ bit_o ^ c2_q;
  assign c2_n  = (t1 & bit_o) | (t1 & c2_q) | (bit_o & c2_q);
  // Serial negate: copy through the first one, invert after it.
  assign nbit  = sbit ^ seen_q;

  // Restoring division step on the magnitude.
  assign trial     = {rem_q, dvd_q[SUM_BITS-1]};
  assign ge        = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};

  assign qb   = dvd_q[0];
  assign rbit = qb ^ (sign_q & seen_q);

  // Outputs of the sequencer.
  always_comb begin
    in_ready = (state_q == ST_IDLE);
    load_out = (state_q == ST_DONE) && (!out_valid_q || avg_o.ready);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SUM;
          cnt_d   = '0;
        end
      end
      ST_SUM: begin
        cnt_d = cnt_q + CNT_BITS'(1);
        if (sum_last) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_BITS'(1);
        if (div_last) begin
          state_d = ST_NEG;
          cnt_d   = '0;
        end
      end
      ST_NEG: begin
        cnt_d = cnt_q + CNT_BITS'(1);
        if (neg_last) begin
          state_d = ST_DONE;
          cnt_d   = '0;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      wl_q        <= LEN_RESET;
      fill_q      <= '0;
      slot_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        wl_q   <= cfg_data_i;
        fill_q <= '0;
        slot_q <= '0;
        sum_q  <= '0;
      end else if (accept) begin
        if (filling) begin
          fill_q <= fill_inc;
        end
        slot_q <= next_slot;
      end else if (state_q == ST_SUM) begin
        sum_q <= {sbit, sum_q[SUM_BITS-1:1]};
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (avg_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ring: read the leaving sample and write the new one in the same transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      old_q              <= ring_mem[cur_slot];
      ring_mem[cur_slot] <= smp_i.sample;
    end else if (state_q == ST_SUM) begin
      old_q <= {old_q[SAMPLE_BITS-1], old_q[SAMPLE_BITS-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q  <= smp_i.sample;
      sub_q  <= !filling;
      div_q  <= filling ? fill_inc : len;
      full_q <= filling ? (fill_inc >= len) : 1'b1;
      c1_q   <= 1'b0;
      c2_q   <= !filling;
      seen_q <= 1'b0;
    end
    if (state_q == ST_SUM) begin
      smp_q  <= {smp_q[SAMPLE_BITS-1], smp_q[SAMPLE_BITS-1:1]};
      c1_q   <= c1_n;
      c2_q   <= c2_n;
      seen_q <= seen_q | sbit;
      neg_q  <= {nbit, neg_q[SUM_BITS-1:1]};
      if (sum_last) begin
        dvd_q  <= sbit ? {nbit, neg_q[SUM_BITS-1:1]} : {sbit, sum_q[SUM_BITS-1:1]};
        sign_q <= sbit;
        rem_q  <= '0;
      end
    end
    if (state_q == ST_DIV) begin
      rem_q <= ge ? trial_sub[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
      dvd_q <= {dvd_q[SUM_BITS-2:0], ge};
      if (div_last) begin
        seen_q <= 1'b0;
      end
    end
    if (state_q == ST_NEG) begin
      res_q  <= {rbit, res_q[SAMPLE_BITS-1:1]};
      dvd_q  <= {1'b0, dvd_q[SUM_BITS-1:1]};
      seen_q <= seen_q | qb;
    end
    if (load_out) begin
      mean_q     <= res_q;
      full_out_q <= full_q;
    end
  end

  assign smp_i.ready       = in_ready;
  assign avg_o.valid       = out_valid_q;
  assign avg_o.mean_value  = mean_q;
  assign avg_o.window_full = full_out_q;

  `ASSERT_CLK(a_fill_slot_in_window, clk_i, rst_ni, (fill_q <= len) && (slot_w < len_w))
  `ASSERT_CLK(a_rem_below_div, clk_i, rst_ni, (state_q == ST_DIV) |-> (rem_q < div_q))
  `ASSERT_CLK(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_DONE))

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sliding window average block.
`timescale 1ns / 1ps

module tb_top;
  import swa_pkg::*;

  localparam int unsigned SW    = SAMPLE_BITS_DEF;
  localparam int unsigned DEPTH = WINDOW_DEPTH_DEF;
  // sum width is sample width plus clog2 of the depth
  localparam int unsigned LATENCY = 2 * (SW + $clog2(DEPTH)) + SW + 2;
  localparam logic [LEN_BITS-1:0] LEN_MAX_CODE = '1;

  typedef logic signed [SW-1:0] sample_t;

  typedef struct packed {
    logic signed [SW-1:0] mean;
    logic                 full;
  } avg_rec_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [LEN_BITS-1:0] cfg_data;

  swa_in_if  #(.SAMPLE_BITS(SW)) smp_if ();
  swa_out_if #(.SAMPLE_BITS(SW)) avg_if ();

  sliding_window_average #(
    .WINDOW_DEPTH(DEPTH),
    .SAMPLE_BITS (SW)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .smp_i     (smp_if),
    .avg_o     (avg_if)
  );

  // Predictor state
  sample_t     ring_q [DEPTH];
  longint      sum_acc;
  int unsigned slot_ptr;
  int unsigned filled;
  int unsigned win_len;

  avg_rec_t    pending_means[$];
  avg_rec_t    head_rec;
  int unsigned mismatch_count;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void note_mismatch(input string msg);
    if (mismatch_count < 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endfunction

  function automatic void clear_window(input logic [LEN_BITS-1:0] len);
    win_len  = len;
    filled   = 0;
    slot_ptr = 0;
    sum_acc  = 0;
  endfunction

  // Expected mean for one accepted sample
  function automatic void predict_mean(input sample_t s);
    int unsigned len;
    longint      divisor;
    longint      quot;
    avg_rec_t    rec;
    len = (win_len == 0) ? 1 : ((win_len > DEPTH) ? DEPTH : win_len);
    if (slot_ptr >= len) slot_ptr = 0;
    if (filled < len) begin
      filled++;
      divisor = filled;
    end else begin
      sum_acc -= ring_q[slot_ptr];
      divisor = len;
    end
    ring_q[slot_ptr] = s;
    sum_acc += s;
    slot_ptr++;
    if (slot_ptr >= len) slot_ptr = 0;
    quot = sum_acc / divisor;  // truncates toward zero
    rec.mean = quot[SW-1:0];
    rec.full = (filled >= len);
    pending_means.push_back(rec);
  endfunction

  // Result side: random backpressure and compare
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      avg_if.ready <= 1'b0;
    end else begin
      avg_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      if (avg_if.valid && avg_if.ready) begin
        if (pending_means.size() == 0) begin
          note_mismatch($sformatf("unexpected result mean=%0d full=%0b",
                                  avg_if.mean_value, avg_if.window_full));
        end else begin
          head_rec = pending_means.pop_front();
          if (avg_if.mean_value !== head_rec.mean)
            note_mismatch($sformatf("mean_value expected %0d got %0d",
                                    head_rec.mean, avg_if.mean_value));
          if (avg_if.window_full !== head_rec.full)
            note_mismatch($sformatf("window_full expected %0b got %0b",
                                    head_rec.full, avg_if.window_full));
        end
      end
    end
  end

  // valid stays high between back-to-back transfers; within this task only the idle path lowers it
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk); while (!smp_if.ready);
    predict_mean(s);
  endtask

  task automatic drain_results();
    smp_if.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic set_window(input logic [LEN_BITS-1:0] len);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_we   <= 1'b0;
    clear_window(len);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2, 3, 4: return sample_t'($signed($urandom_range(20)) - 10);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic test_reset_length();
    // default length 16, fill phase with both rails
    send_sample(sample_t'(32767));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(-3));
  endtask

  task automatic test_single_tap();
    set_window(LEN_BITS'(1));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(0));
    // zero length behaves as one
    set_window(LEN_BITS'(0));
    send_sample(sample_t'(-5));
    send_sample(sample_t'(7));
  endtask

  task automatic test_short_wrap();
    set_window(LEN_BITS'(2));
    send_sample(sample_t'(3));
    send_sample(sample_t'(-4));
    send_sample(sample_t'(-5));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(32767));
    set_window(LEN_BITS'(3));
    send_sample(sample_t'(-7));
    send_sample(sample_t'(-7));
    send_sample(sample_t'(-8));
    send_sample(sample_t'(1));
  endtask

  task automatic test_saturated_length();
    set_window(LEN_MAX_CODE);
    send_sample(sample_t'(100));
    send_sample(sample_t'(-101));
  endtask

  // full 64-deep window pinned at each rail, second half with an oversize length
  task automatic test_full_window_extremes();
    set_window(LEN_BITS'(DEPTH));
    repeat (DEPTH + 1) send_sample(sample_t'(-32768));
    set_window(LEN_BITS'(100));
    repeat (DEPTH + 1) send_sample(sample_t'(32767));
  endtask

  task automatic test_random_stream(input int unsigned src_pct, input int unsigned snk_pct,
                                    input int unsigned n_items);
    int unsigned left;
    int unsigned chunk;
    logic [LEN_BITS-1:0] len;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(9))
        0:       len = ($urandom_range(1) != 0) ? LEN_MAX_CODE : LEN_BITS'(0);
        1:       len = LEN_BITS'($urandom_range(127, DEPTH + 1));
        2, 3, 4: len = LEN_BITS'($urandom_range(8, 1));
        default: len = LEN_BITS'($urandom_range(DEPTH, 1));
      endcase
      set_window(len);
      chunk = $urandom_range(90, 20);
      if (chunk > left) chunk = left;
      repeat (chunk) send_sample(rand_sample());
      left -= chunk;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    smp_if.valid   = 1'b0;
    smp_if.sample  = '0;
    avg_if.ready   = 1'b0;
    mismatch_count = 0;
    src_idle_pct   = 26;
    snk_idle_pct   = 86;
    clear_window(LEN_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_length();
    test_single_tap();
    test_short_wrap();
    test_saturated_length();
    test_full_window_extremes();
    test_random_stream(26, 86, 90);
    test_random_stream(86, 26, 90);
    test_random_stream(0, 0, 90);
    drain_results();

    if (pending_means.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_means.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
